// ===== hw/rtl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the line-of-sight block checkers.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GTLOS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define GTLOS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/gtlos_pkg.sv =====
// -----------------------------------------------------------------------------
// gtlos_pkg
// Shared constants for the grid thick line-of-sight block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gtlos_pkg;

	// Item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 9'd256;

	// Width to which a cell mask is widened before class selection
	localparam int MASK_EXT_W = 8;

endpackage

`default_nettype wire

// ===== hw/rtl/grid_thick_line_of_sight_core.sv =====
// -----------------------------------------------------------------------------
// grid_thick_line_of_sight_core
// Grid map of per-class traversability masks with a thick line-of-sight walker.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item. kind selects a
//   cell write (start_x/start_y/cell_mask) or a query (start, end, agent_class).
//   Output channel (out_valid/out_ready) returns one beat per item: visible,
//   always 0 for a write.
//   One item is worked on at a time; in_ready is high only while the walker is
//   idle, but a result still waiting in the output register does not hold it.
//   Steps: a write goes from ST_IDLE straight to ST_DONE. A straight query
//   runs ST_SETUP, one ST_STR step per cell, ST_DRAIN and ST_DONE. A diagonal
//   query runs ST_SETUP, ST_SEP_MUL, ST_SEP_ADD, then ST_W_C0 and ST_W_C1 per
//   cell along the major axis (da + 1 cells), ST_W_MUL, ST_W_CA and ST_W_CB on
//   each of the m steps where the minor coordinate moves, then ST_DRAIN and
//   ST_DONE. The single map read port, one cell read per cycle, paces this.
//   A query stops early at the first blocked cell.
//   Grid width and height must be written via cfg_we/cfg_index/cfg_data while
//   idle (not enforced). Reset sets both to 256 and empties the pipeline; map
//   contents are not cleared and must be written before they are queried.
//   A stalled receiver holds the result in the output register; the walker
//   may take one more item and then waits with its result until that frees.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_thick_line_of_sight_core #(
	parameter int COORD_BITS    = 8,
	parameter int AGENT_CLASSES = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [COORD_BITS-1:0]             start_x,
	input  logic [COORD_BITS-1:0]             start_y,
	input  logic [COORD_BITS-1:0]             end_x,
	input  logic [COORD_BITS-1:0]             end_y,
	input  logic [1:0]                        agent_class,
	input  logic [3:0]                        cell_mask,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              visible,
	input  logic                              cfg_we,
	input  logic [gtlos_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gtlos_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import gtlos_pkg::*;

	localparam int CW    = COORD_BITS + 2;
	localparam int UW    = COORD_BITS + 1;
	localparam int TW    = COORD_BITS + 3;
	localparam int SQW   = 2 * UW;
	localparam int AW    = 2 * COORD_BITS;
	localparam int DEPTH = 1 << AW;
	localparam int CMPW  = (COORD_BITS > CFG_DATA_W) ? COORD_BITS : CFG_DATA_W;

	// State codes
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SETUP   = 4'd1;
	localparam logic [3:0] ST_SEP_MUL = 4'd2;
	localparam logic [3:0] ST_SEP_ADD = 4'd3;
	localparam logic [3:0] ST_STR     = 4'd4;
	localparam logic [3:0] ST_W_C0    = 4'd5;
	localparam logic [3:0] ST_W_C1    = 4'd6;
	localparam logic [3:0] ST_W_MUL   = 4'd7;
	localparam logic [3:0] ST_W_CA    = 4'd8;
	localparam logic [3:0] ST_W_CB    = 4'd9;
	localparam logic [3:0] ST_DRAIN   = 4'd10;
	localparam logic [3:0] ST_DONE    = 4'd11;

	// Control
	logic [3:0]            state_q;
	logic [CFG_DATA_W-1:0] grid_w_q;
	logic [CFG_DATA_W-1:0] grid_h_q;
	logic                  out_valid_q;
	logic                  chk_s1;

	// Datapath
	logic [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [1:0]            cls_q;
	logic signed [CW-1:0]  ma_q, mb_q, mend_q;
	logic [COORD_BITS-1:0] da_q, db_q;
	logic                  sa_neg_q, sb_neg_q, a_is_x_q;
	logic [UW-1:0]         err_q, t1_q, t2_q;
	logic [SQW-1:0]        sq1_q, sq2_q, sep_q;
	logic                  res_q, visible_q, ok_s1;

	// Map memory
	logic [AGENT_CLASSES-1:0] map_mem [DEPTH];
	logic [AGENT_CLASSES-1:0] rd_s1;

	// ---------------------------------------------------------------------
	// Setup: deltas, step directions and major axis
	logic [COORD_BITS-1:0] dx, dy;
	logic                  sxn, syn, su_x_major, su_straight;

	always_comb begin
		dx          = (sx_q >= ex_q) ? (sx_q - ex_q) : (ex_q - sx_q);
		dy          = (sy_q >= ey_q) ? (sy_q - ey_q) : (ey_q - sy_q);
		sxn         = !(sx_q < ex_q);
		syn         = !(sy_q < ey_q);
		su_x_major  = (dx != '0) && ((dy == '0) || (dx > dy));
		su_straight = (dx == '0) || (dy == '0);
	end

	// Unit steps along each axis: +1 or -1, and twice the minor step
	logic signed [CW-1:0] sa_v, sb_v, sb2_v;

	always_comb begin
		sa_v  = sa_neg_q ? {CW{1'b1}} : CW'(1);
		sb_v  = sb_neg_q ? {CW{1'b1}} : CW'(1);
		sb2_v = {sb_v[CW-2:0], 1'b0};
	end

	// Error term update on a major step
	logic [UW-1:0] err_n;
	logic [TW-1:0] t1_w, t2_w, da_w, db_w, err2_w;

	always_comb begin
		err_n  = err_q + UW'(db_q);
		da_w   = TW'(da_q);
		db_w   = TW'(db_q);
		err2_w = TW'({err_n, 1'b0});
		t1_w   = err2_w - da_w - db_w;
		t2_w   = (da_w << 1) + da_w + db_w - err2_w;
	end

	// Shared squarers: separation first, then the corner terms
	logic [UW-1:0]  m1_op, m2_op;
	logic [SQW-1:0] prod1, prod2;

	always_comb begin
		m1_op = (state_q == ST_SEP_MUL) ? UW'(da_q) : t1_q;
		m2_op = (state_q == ST_SEP_MUL) ? UW'(db_q) : t2_q;
		prod1 = m1_op * m1_op;
		prod2 = m2_op * m2_op;
	end

	// Cell to read this cycle, in major/minor coordinates
	logic signed [CW-1:0] ia, ib, cx, cy;
	logic                 issue;

	always_comb begin
		ia    = ma_q;
		ib    = mb_q;
		issue = 1'b0;
		unique case (state_q)
			ST_STR: begin
				issue = (ma_q != mend_q);
			end
			ST_W_C0: begin
				issue = 1'b1;
			end
			ST_W_C1: begin
				ib    = mb_q + sb_v;
				issue = 1'b1;
			end
			ST_W_CA: begin
				ia    = ma_q + sa_v;
				issue = (sq1_q < sep_q);
			end
			ST_W_CB: begin
				ib    = mb_q + sb2_v;
				issue = (sq2_q < sep_q);
			end
			default: begin
				issue = 1'b0;
			end
		endcase
		cx = a_is_x_q ? ia : ib;
		cy = a_is_x_q ? ib : ia;
	end

	// Bounds: non-negative, inside the map and inside the configured grid
	logic          cell_ok;
	logic [AW-1:0] rd_addr;

	always_comb begin
		cell_ok = !cx[CW-1] && !cy[CW-1] && !cx[COORD_BITS] && !cy[COORD_BITS]
			&& (CMPW'(cx[COORD_BITS-1:0]) < CMPW'(grid_w_q))
			&& (CMPW'(cy[COORD_BITS-1:0]) < CMPW'(grid_h_q));
		rd_addr = {cy[COORD_BITS-1:0], cx[COORD_BITS-1:0]};
	end

	// Write side of the map
	logic                     map_we;
	logic [AW-1:0]            wr_addr;
	logic [MASK_EXT_W-1:0]    mask_ext;
	logic [AGENT_CLASSES-1:0] wr_data;

	always_comb begin
		map_we   = (state_q == ST_IDLE) && in_valid && (kind == KIND_WRITE);
		wr_addr  = {start_y, start_x};
		mask_ext = MASK_EXT_W'(cell_mask);
		wr_data  = mask_ext[AGENT_CLASSES-1:0];
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_s1 <= map_mem[rd_addr];
		end
	end

	// Check of the cell read last cycle
	logic [MASK_EXT_W-1:0] rd_ext;
	logic                  fail;

	always_comb begin
		rd_ext = MASK_EXT_W'(rd_s1);
		fail   = chk_s1 && !(ok_s1 && rd_ext[{1'b0, cls_q}]);
	end

	// ---------------------------------------------------------------------
	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grid_w_q    <= GRID_SIZE_RESET;
			grid_h_q    <= GRID_SIZE_RESET;
			out_valid_q <= 1'b0;
			chk_s1      <= 1'b0;
		end else begin
			chk_s1 <= issue;
			ok_s1  <= cell_ok;

			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  grid_w_q <= cfg_data;
					REG_GRID_HEIGHT: grid_h_q <= cfg_data;
					default: ;
				endcase
			end

			// output register
			if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				visible_q   <= res_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sx_q  <= start_x;
						sy_q  <= start_y;
						ex_q  <= end_x;
						ey_q  <= end_y;
						cls_q <= agent_class;
						res_q <= 1'b0;
						state_q <= (kind == KIND_WRITE) ? ST_DONE : ST_SETUP;
					end
				end
				ST_SETUP: begin
					a_is_x_q <= su_x_major;
					ma_q     <= su_x_major ? {2'b00, sx_q} : {2'b00, sy_q};
					mend_q   <= su_x_major ? {2'b00, ex_q} : {2'b00, ey_q};
					mb_q     <= su_x_major ? {2'b00, sy_q} : {2'b00, sx_q};
					sa_neg_q <= su_x_major ? sxn : syn;
					sb_neg_q <= su_x_major ? syn : sxn;
					da_q     <= su_x_major ? dx : dy;
					db_q     <= su_x_major ? dy : dx;
					err_q    <= '0;
					state_q  <= su_straight ? ST_STR : ST_SEP_MUL;
				end
				ST_SEP_MUL: begin
					sq1_q   <= prod1;
					sq2_q   <= prod2;
					state_q <= ST_SEP_ADD;
				end
				ST_SEP_ADD: begin
					sep_q   <= sq1_q + sq2_q;
					state_q <= ST_W_C0;
				end
				ST_STR: begin
					if (fail) begin
						res_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (ma_q == mend_q) begin
						state_q <= ST_DRAIN;
					end else begin
						ma_q <= ma_q + sa_v;
					end
				end
				ST_W_C0: begin
					if (fail) begin
						res_q   <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_W_C1;
					end
				end
				ST_W_C1: begin
					if (fail) begin
						res_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (ma_q == mend_q) begin
						state_q <= ST_DRAIN;
					end else begin
						err_q <= err_n;
						t1_q  <= t1_w[UW-1:0];
						t2_q  <= t2_w[UW-1:0];
						if (err_n > UW'(da_q)) begin
							state_q <= ST_W_MUL;
						end else begin
							ma_q    <= ma_q + sa_v;
							state_q <= ST_W_C0;
						end
					end
				end
				ST_W_MUL: begin
					sq1_q <= prod1;
					sq2_q <= prod2;
					if (fail) begin
						res_q   <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_W_CA;
					end
				end
				ST_W_CA: begin
					if (fail) begin
						res_q   <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_W_CB;
					end
				end
				ST_W_CB: begin
					if (fail) begin
						res_q   <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						// minor step taken: move on and rebase the error term
						mb_q    <= mb_q + sb_v;
						ma_q    <= ma_q + sa_v;
						err_q   <= err_q - UW'(da_q);
						state_q <= ST_W_C0;
					end
				end
				ST_DRAIN: begin
					res_q   <= !fail;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign visible   = visible_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gtlos_checker.sv =====
// -----------------------------------------------------------------------------
// gtlos_checker
// Port-level checks for the line-of-sight block, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gtlos_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic kind,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic visible
);

	import gtlos_pkg::*;

	logic       in_beat, out_beat;
	logic [1:0] cnt_q;
	logic       last_kind_q;
	logic       lone_write;

	assign in_beat    = in_valid && in_ready;
	assign out_beat   = out_valid && out_ready;
	assign lone_write = (cnt_q == 2'd1) && (last_kind_q == KIND_WRITE);

	// Items accepted but not yet answered, and kind of the newest one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= 2'd0;
			last_kind_q <= KIND_WRITE;
		end else begin
			if (in_beat && !out_beat) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!in_beat && out_beat) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if (in_beat) begin
				last_kind_q <= kind;
			end
		end
	end

	// a lone outstanding write answers not visible
	`GTLOS_ASSERT_IMP(a_write_result, clk, arst_n, out_beat && lone_write, !visible)
	// one item at a time: ready drops after a beat
	`GTLOS_ASSERT_NXT(a_ready_drop, clk, arst_n, in_beat, !in_ready)
	// no result without an item behind it
	`GTLOS_ASSERT_IMP(a_no_phantom, clk, arst_n, out_valid, cnt_q != 2'd0)
	// at most one result waiting when a new item is taken
	`GTLOS_ASSERT_IMP(a_depth, clk, arst_n, in_ready, cnt_q <= 2'd1)
	// stalled result holds
	`GTLOS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(visible))

endmodule

bind grid_thick_line_of_sight_core gtlos_checker u_gtlos_checker (.*);

`default_nettype wire
